/* design/rbsv_pkg.sv */
// Package for the resonant bass voice core: fixed-point constants, command
// and register codes, sequencer states, and the exp2 and sine lookup tables.
// No dependencies.
package rbsv_pkg;

  localparam int EXP2_TABLE_DEPTH = 256;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int EXP_LOG          = $clog2(EXP2_TABLE_DEPTH);
  localparam int SINE_LOG         = $clog2(SINE_TABLE_DEPTH);

  localparam logic [24:0] ONE_Q24      = 25'd16777216;
  localparam logic [24:0] ENV_MAX      = 25'd33554431;
  localparam logic [24:0] GAIN_CAP     = 25'd25165824;
  localparam logic [31:0] ACCENT_SCALE = 32'd10066330;
  localparam logic [31:0] PI_Q29       = 32'd1686629711;
  localparam logic [63:0] LN2_Q32      = 64'd2977044472;
  localparam logic [27:0] BASE_OFS     = 28'd5242880;
  localparam logic [19:0] CAP_RECIP    = 20'd838861;
  localparam logic [20:0] RAMP_RECIP   = 21'd1342178;
  localparam int          DVD_W        = 43;
  localparam logic [5:0]  ARG_ITERS    = 6'd25;
  localparam logic [5:0]  RATE_ITERS   = 6'd32;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_WAVEFORM   = 3'd0,
    REG_CUTOFF     = 3'd1,
    REG_RESONANCE  = 3'd2,
    REG_ENV_MOD    = 3'd3,
    REG_DECAY      = 3'd4,
    REG_ACCENT     = 3'd5,
    REG_RATE       = 3'd6
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NINIT, ST_NDONE, ST_DIV, ST_GLIDE, ST_PHASE, ST_OCT, ST_ACS,
    ST_ACW, ST_EXP, ST_EXPM, ST_FC, ST_ARG1, ST_ARG2, ST_ARG3, ST_SIN, ST_SINW,
    ST_LOWM, ST_LOW, ST_HIGH, ST_BAND, ST_BANDW, ST_GAIN, ST_OUTM, ST_Y,
    ST_FENV, ST_AENV
  } state_e;

  typedef logic [25:0] exp_tab_t [EXP2_TABLE_DEPTH + 1];
  typedef logic [24:0] sin_tab_t [SINE_TABLE_DEPTH + 1];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [127:0] y;
    logic [127:0] term;
    logic [127:0] sum;
    int          i;
    for (int k = 0; k <= EXP2_TABLE_DEPTH; k++) begin
      y    = (128'(k) * 128'(LN2_Q32)) >> EXP_LOG;
      term = 128'(1) << 32;
      sum  = term;
      i    = 1;
      while (term != 0 && i < 40) begin
        term = 128'(udiv64(64'((term * y) >> 32), 64'(i)));
        sum  = sum + term;
        i    = i + 1;
      end
      t[k] = 26'((sum + 128'd128) >> 8);
    end
    return t;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t     t;
    logic [127:0] x;
    logic [127:0] term;
    logic [127:0] sum;
    int           i;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (128'(k) << 31) >> SINE_LOG;
      term = x;
      sum  = x;
      i    = 1;
      while (term != 0 && i < 20) begin
        term = 128'(udiv64(64'((term * x) >> 31), 64'((2 * i) * (2 * i + 1))));
        term = (term * x) >> 31;
        if (i[0]) sum = sum - term;
        else sum = sum + term;
        i = i + 1;
      end
      t[k] = 25'((sum + 128'd64) >> 7);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();
  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // floor(r * 16384 / 5) for the remainder of the cutoff cap
  function automatic logic [13:0] cap_frac(input logic [2:0] r);
    logic [13:0] v;
    unique case (r)
      3'd0:    v = 14'd0;
      3'd1:    v = 14'd3276;
      3'd2:    v = 14'd6553;
      3'd3:    v = 14'd9830;
      3'd4:    v = 14'd13107;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/resonant_bass_synth_voice_core.sv */
// Top level of the resonant bass voice: oscillator, envelope-swept state
// variable low-pass filter and amplifier on one shared multiplier and divider.
// Depends on rbsv_pkg.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | command, note_step, slide, accent
//  out     | output    | out_valid_o/out_stall_i | sample
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A tick runs 23 sequencer steps, up to 15 of them on the shared 32x32 multiplier,
// and a restoring divide for the filter angle; when the cutoff takes the cap, the
// exp2 multiply and clamp steps are skipped. A note on with glide runs a divide
// for the glide rate; other commands complete in the idle state. Reset clears all
// voice state and loads register defaults. A held output stalls the sequencer only
// when the next sample is ready.
module resonant_bass_synth_voice_core
  import rbsv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [30:0]        note_step_i,
  input  logic               slide_i,
  input  logic               accent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [24:0]        cfg_data_i
);

  state_e state_q, state_d;

  logic        waveform_q;
  logic [15:0] cutoff_q;
  logic [24:0] res_q, envmod_q, decay_q, adepth_q;
  logic [17:0] rate_cfg_q;

  logic [31:0] phase_acc_q, phase_acc_d, phase_step_q, phase_step_d;
  logic [31:0] step_target_q, step_target_d, step_rate_q, step_rate_d;
  logic        sliding_q, sliding_d, gate_q, gate_d, accent_q, accent_d;
  logic signed [31:0] low_q, low_d, band_q, band_d;
  logic [24:0] fenv_q, fenv_d, amp_q, amp_d;

  logic        out_valid_q, out_valid_d;
  logic signed [15:0] out_q, out_d;

  logic [17:0] rate_q, ramp_q;
  logic [33:0] cap_q;
  logic [27:0] base_q;

  logic signed [31:0] mul_a, mul_b, osc_q, osc_d, high_q, high_d;
  logic signed [63:0] p_q;
  logic        mul_en;
  logic [39:0] mq;
  logic [29:0] oct_q, oct_d;
  logic [25:0] lo_q, lo_d, f_q, f_d;
  logic [33:0] fc_q, fc_d;
  logic [63:0] dacc_q, dacc_d;
  logic [24:0] gain_q, gain_d;
  logic signed [32:0] diff_q, diff_d;
  logic [17:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        div_note_q, div_note_d;

  logic [17:0] rate_eff;
  logic [21:0] y9, r5w;
  logic [41:0] q5p;
  logic [19:0] q5;
  logic [27:0] q3920;
  logic [16:0] r17;
  logic [19:0] x3;
  logic [40:0] rp;

  always_comb begin
    rate_eff = (rate_cfg_q == 18'd0) ? 18'd1 : rate_cfg_q;
    y9       = 22'(rate_eff) * 22'd9;
    q5p      = 42'(y9) * 42'(CAP_RECIP);
    q5       = q5p[41:22];
    r5w      = y9 - 22'(q5) * 22'd5;
    q3920    = 28'(cutoff_q) * 28'd3920;
    r17      = 17'(q3920[15:0]) + 17'(q3920[27:16]);
    x3       = 20'(rate_eff) * 20'd3;
    rp       = 41'(x3) * 41'(RAMP_RECIP);
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_eff;
    cap_q  <= {q5, 14'd0} + 34'(cap_frac(r5w[2:0]));
    base_q <= BASE_OFS + q3920 + 28'(q3920[27:16]) + 28'(r17 >= 17'd65535);
    ramp_q <= (rp[40:26] == 15'd0) ? 18'd1 : 18'(rp[40:26]);
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;
  assign mq          = p_q[63:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= 1'b0;
      cutoff_q   <= 16'd26214;
      res_q      <= 25'd1928415;
      envmod_q   <= 25'd10066329;
      decay_q    <= 25'd16776612;
      adepth_q   <= 25'd8388608;
      rate_cfg_q <= 18'd44100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WAVEFORM:  waveform_q <= cfg_data_i[0];
        REG_CUTOFF:    cutoff_q   <= cfg_data_i[15:0];
        REG_RESONANCE: res_q      <= cfg_data_i;
        REG_ENV_MOD:   envmod_q   <= cfg_data_i;
        REG_DECAY:     decay_q    <= cfg_data_i;
        REG_ACCENT:    adepth_q   <= cfg_data_i;
        REG_RATE:      rate_cfg_q <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_acc_q   <= '0;
      phase_step_q  <= '0;
      step_target_q <= '0;
      step_rate_q   <= '0;
      sliding_q     <= 1'b0;
      gate_q        <= 1'b0;
      accent_q      <= 1'b0;
      low_q         <= '0;
      band_q        <= '0;
      fenv_q        <= '0;
      amp_q         <= '0;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
      div_note_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_acc_q   <= phase_acc_d;
      phase_step_q  <= phase_step_d;
      step_target_q <= step_target_d;
      step_rate_q   <= step_rate_d;
      sliding_q     <= sliding_d;
      gate_q        <= gate_d;
      accent_q      <= accent_d;
      low_q         <= low_d;
      band_q        <= band_d;
      fenv_q        <= fenv_d;
      amp_q         <= amp_d;
      out_valid_q   <= out_valid_d;
      cnt_q         <= cnt_d;
      div_note_q    <= div_note_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) p_q <= 64'(mul_a) * 64'(mul_b);
    out_q  <= out_d;
    osc_q  <= osc_d;
    high_q <= high_d;
    oct_q  <= oct_d;
    lo_q   <= lo_d;
    f_q    <= f_d;
    fc_q   <= fc_d;
    dacc_q <= dacc_d;
    gain_q <= gain_d;
    diff_q <= diff_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    dvd_q  <= dvd_d;
  end

  logic [31:0]       ns;
  logic              hit;
  logic [EXP_LOG:0]  e_lo;
  logic [SINE_LOG:0] s_lo, s_hi;
  logic [25:0]       e_diff;
  logic [24:0]       s_diff, arg, s_sum;
  logic [44:0]       fc_w;
  logic [63:0]       dsum;
  logic [18:0]       sh;
  logic              ge;
  logic [32:0]       mag;
  logic [26:0]       gsum;
  logic signed [27:0] ys;
  logic              can_load;

  always_comb begin
    state_d       = state_q;
    phase_acc_d   = phase_acc_q;
    phase_step_d  = phase_step_q;
    step_target_d = step_target_q;
    step_rate_d   = step_rate_q;
    sliding_d     = sliding_q;
    gate_d        = gate_q;
    accent_d      = accent_q;
    low_d         = low_q;
    band_d        = band_q;
    fenv_d        = fenv_q;
    amp_d         = amp_q;
    out_valid_d   = out_valid_q & out_stall_i;
    out_d         = out_q;
    cnt_d         = cnt_q;
    div_note_d    = div_note_q;
    osc_d         = osc_q;
    high_d        = high_q;
    oct_d         = oct_q;
    lo_d          = lo_q;
    f_d           = f_q;
    fc_d          = fc_q;
    dacc_d        = dacc_q;
    gain_d        = gain_q;
    diff_d        = diff_q;
    rem_d         = rem_q;
    dsr_d         = dsr_q;
    dvd_d         = dvd_q;
    mul_a         = '0;
    mul_b         = '0;
    mul_en        = 1'b1;
    can_load      = !out_valid_q || !out_stall_i;

    ns     = phase_step_q + step_rate_q;
    hit    = (step_rate_q == 32'd0) ||
             (!step_rate_q[31] ? (ns >= step_target_q) : (ns <= step_target_q));
    e_lo   = {1'b0, oct_q[23 -: EXP_LOG]};
    e_diff = EXP_TAB[e_lo + 1'b1] - EXP_TAB[e_lo];
    arg    = (dvd_q[24:0] > ONE_Q24) ? ONE_Q24 : dvd_q[24:0];
    s_lo   = arg[24 -: SINE_LOG + 1];
    s_hi   = (s_lo == (SINE_LOG + 1)'(SINE_TABLE_DEPTH)) ? s_lo : s_lo + 1'b1;
    s_diff = SIN_TAB[s_hi] - SIN_TAB[s_lo];
    s_sum  = lo_q[24:0] + mq[24:0];
    fc_w   = 45'(mq[29:0]) << oct_q[27:24];
    dsum   = dacc_q + {p_q[46:0], 17'd0};
    sh     = {rem_q, dvd_q[DVD_W-1]};
    ge     = (sh >= {1'b0, dsr_q});
    mag    = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
    gsum   = 27'(amp_q) + mq[26:0];
    ys     = $signed(p_q[63:36]);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (command_i)
            CMD_TICK: state_d = ST_GLIDE;
            CMD_NOTE_ON: begin
              step_target_d = 32'(note_step_i);
              if (slide_i && phase_step_q != 32'd0) begin
                sliding_d = 1'b1;
                diff_d    = $signed(33'(note_step_i)) - $signed(33'(phase_step_q));
                state_d   = ST_NINIT;
              end else begin
                phase_step_d = 32'(note_step_i);
                sliding_d    = 1'b0;
              end
              fenv_d   = ONE_Q24;
              amp_d    = ONE_Q24;
              gate_d   = 1'b1;
              accent_d = accent_i;
            end
            CMD_NOTE_OFF: gate_d = 1'b0;
            default: ;
          endcase
        end
      end
      ST_NINIT: begin
        dsr_d      = ramp_q;
        rem_d      = '0;
        dvd_d      = {mag[31:0], 11'd0};
        cnt_d      = RATE_ITERS;
        div_note_d = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? 18'(sh - {1'b0, dsr_q}) : sh[17:0];
        dvd_d = {dvd_q[DVD_W-2:0], ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = div_note_q ? ST_NDONE : ST_SIN;
      end
      ST_NDONE: begin
        step_rate_d = diff_q[32] ? (32'd0 - dvd_q[31:0]) : dvd_q[31:0];
        state_d     = ST_IDLE;
      end
      ST_GLIDE: begin
        if (sliding_q) begin
          if (hit) begin
            phase_step_d = step_target_q;
            sliding_d    = 1'b0;
          end else begin
            phase_step_d = ns;
          end
        end
        state_d = ST_PHASE;
      end
      ST_PHASE: begin
        phase_acc_d = phase_acc_q + phase_step_q;
        mul_a       = 32'(envmod_q);
        mul_b       = 32'(fenv_q);
        state_d     = ST_OCT;
      end
      ST_OCT: begin
        oct_d   = mq[29:0] + {mq[28:0], 1'b0};
        osc_d   = waveform_q ? (phase_acc_q[31] ? -32'sd16777216 : 32'sd16777216)
                             : ($signed(phase_acc_q) >>> 7);
        mul_a   = ACCENT_SCALE;
        mul_b   = 32'(adepth_q);
        state_d = ST_ACS;
      end
      ST_ACS: begin
        mul_a   = 32'(oct_q);
        mul_b   = 32'(ONE_Q24) + mq[31:0];
        state_d = ST_ACW;
      end
      ST_ACW: begin
        if (accent_q) oct_d = mq[29:0];
        state_d = ST_EXP;
      end
      ST_EXP: begin
        if (oct_q[29:28] != 2'd0) begin
          fc_d    = cap_q;
          state_d = ST_ARG1;
        end else begin
          lo_d    = EXP_TAB[e_lo];
          mul_a   = 32'(e_diff);
          mul_b   = 32'(24'(oct_q[23:0] << EXP_LOG));
          state_d = ST_EXPM;
        end
      end
      ST_EXPM: begin
        mul_a   = 32'(base_q);
        mul_b   = 32'(lo_q) + mq[31:0];
        state_d = ST_FC;
      end
      ST_FC: begin
        fc_d    = (fc_w > 45'(cap_q)) ? cap_q : fc_w[33:0];
        state_d = ST_ARG1;
      end
      ST_ARG1: begin
        mul_a   = 32'(fc_q[16:0]);
        mul_b   = PI_Q29;
        state_d = ST_ARG2;
      end
      ST_ARG2: begin
        dacc_d  = p_q;
        mul_a   = 32'(fc_q[33:17]);
        mul_b   = PI_Q29;
        state_d = ST_ARG3;
      end
      ST_ARG3: begin
        rem_d      = dsum[63:46];
        dvd_d      = {dsum[45:21], 18'd0};
        dsr_d      = rate_q;
        cnt_d      = ARG_ITERS;
        div_note_d = 1'b0;
        state_d    = ST_DIV;
      end
      ST_SIN: begin
        lo_d    = 26'(SIN_TAB[s_lo]);
        mul_a   = 32'(s_diff);
        mul_b   = 32'(24'(arg[23:0] << SINE_LOG));
        state_d = ST_SINW;
      end
      ST_SINW: begin
        f_d     = {s_sum, 1'b0};
        state_d = ST_LOWM;
      end
      ST_LOWM: begin
        mul_a   = 32'(f_q);
        mul_b   = band_q;
        state_d = ST_LOW;
      end
      ST_LOW: begin
        low_d   = low_q + mq[31:0];
        mul_a   = 32'(res_q);
        mul_b   = band_q;
        state_d = ST_HIGH;
      end
      ST_HIGH: begin
        high_d  = osc_q - low_q - mq[31:0];
        state_d = ST_BAND;
      end
      ST_BAND: begin
        mul_a   = 32'(f_q);
        mul_b   = high_q;
        state_d = ST_BANDW;
      end
      ST_BANDW: begin
        band_d  = band_q + mq[31:0];
        mul_a   = 32'(amp_q);
        mul_b   = 32'(adepth_q);
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        if (accent_q) gain_d = (gsum > 27'(GAIN_CAP)) ? GAIN_CAP : gsum[24:0];
        else gain_d = amp_q;
        state_d = ST_OUTM;
      end
      ST_OUTM: begin
        mul_a   = low_q;
        mul_b   = 32'(gain_q);
        state_d = ST_Y;
      end
      ST_Y: begin
        mul_en = can_load;
        mul_a  = 32'(fenv_q);
        mul_b  = 32'(decay_q);
        if (can_load) begin
          out_valid_d = 1'b1;
          if (ys > 28'sd32767) out_d = 16'sh7fff;
          else if (ys < -28'sd32768) out_d = -16'sh8000;
          else out_d = ys[15:0];
          state_d = ST_FENV;
        end
      end
      ST_FENV: begin
        fenv_d  = (mq[39:25] != 15'd0) ? ENV_MAX : mq[24:0];
        mul_a   = 32'(amp_q);
        mul_b   = 32'(decay_q);
        state_d = ST_AENV;
      end
      ST_AENV: begin
        if (gate_q) amp_d = ONE_Q24;
        else amp_d = (mq[39:25] != 15'd0) ? ENV_MAX : mq[24:0];
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* verif/rbsv_voice_checker.sv */
`timescale 1ns / 1ps
// Checker for the resonant bass voice core: watches the command, sample and
// register channels, predicts each sample and compares it. Depends on rbsv_pkg.
module rbsv_voice_checker
  import rbsv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         command_i,
  input  logic [30:0]        note_step_i,
  input  logic               slide_i,
  input  logic               accent_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] sample_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [24:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint Q24_ONE   = 64'sd16777216;
  localparam longint ENV_LIMIT = 64'sd33554431;
  localparam longint GAIN_LIM  = 64'sd25165824;
  localparam longint ACC_SCALE = 64'sd10066330;
  localparam longint PI_Q29V   = 64'sd1686629711;
  localparam longint LN2_Q32V  = 64'sd2977044472;

  longint exp_lut [0:EXP2_TABLE_DEPTH];
  longint sine_lut[0:SINE_TABLE_DEPTH];

  logic        wave_sel;
  longint      cutoff_pos, damping, env_depth, decay, accent_amt, rate_hz;
  logic [31:0] phase, step, target, glide_rate;
  logic        gliding, gate, accented;
  int          lp_state, bp_state;
  longint      cutoff_env, amp_level;

  logic signed [15:0] sample_queue[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = sample_queue.size();

  initial begin
    logic [127:0] y, term, sum;
    longint       ssum;
    int           i;
    for (int k = 0; k <= EXP2_TABLE_DEPTH; k++) begin
      y = (128'(k) * 128'(LN2_Q32V)) / EXP2_TABLE_DEPTH;
      term = 128'(1) << 32;
      sum = term;
      for (i = 1; term != 0 && i < 40; i++) begin
        term = ((term * y) >> 32) / i;
        sum = sum + term;
      end
      exp_lut[k] = longint'((sum + 128) >> 8);
    end
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      y = (128'(k) << 31) / SINE_TABLE_DEPTH;
      term = y;
      ssum = longint'(y);
      for (i = 1; term != 0 && i < 20; i++) begin
        term = ((term * y) >> 31) / ((2 * i) * (2 * i + 1));
        term = (term * y) >> 31;
        if (i % 2 == 1) ssum = ssum - longint'(term);
        else ssum = ssum + longint'(term);
      end
      sine_lut[k] = (ssum + 64) >>> 7;
    end
  end

  function automatic longint mul_q24(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  function automatic longint lut_lookup(bit use_sine, longint pos);
    longint p, idx, fr, lo, hi, depth;
    depth = use_sine ? SINE_TABLE_DEPTH : EXP2_TABLE_DEPTH;
    p = pos * depth;
    idx = p >> 24;
    fr = p & 64'hFFFFFF;
    if (idx >= depth) return use_sine ? sine_lut[depth] : exp_lut[depth];
    lo = use_sine ? sine_lut[idx] : exp_lut[idx];
    hi = use_sine ? sine_lut[idx + 1] : exp_lut[idx + 1];
    return lo + (((hi - lo) * fr) >> 24);
  endfunction

  function automatic longint env_clip(longint v);
    if (v > ENV_LIMIT) return ENV_LIMIT;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic longint svf_coeff();
    longint       rate, cap, base, oct, m;
    logic [127:0] fc, arg;
    rate = (rate_hz != 0) ? rate_hz : 1;
    cap = (9 * (rate << 16)) / 20;
    base = (80 << 16) + ((3920 * cutoff_pos) << 16) / 65535;
    oct = 3 * mul_q24(env_depth, cutoff_env);
    if (accented) oct = mul_q24(oct, Q24_ONE + mul_q24(ACC_SCALE, accent_amt));
    if (oct >= 16 * Q24_ONE) begin
      fc = 128'(cap);
    end else begin
      m = lut_lookup(1'b0, oct & 64'hFFFFFF);
      fc = 128'((base * m) >> 24) << (oct >> 24);
      if (fc * 20 > 128'(9 * (rate << 16))) fc = 128'(cap);
    end
    arg = (fc * 128'(PI_Q29V)) / 128'(rate << 21);
    if (arg > 128'(Q24_ONE)) arg = 128'(Q24_ONE);
    return 2 * lut_lookup(1'b1, longint'(arg));
  endfunction

  function automatic logic signed [15:0] voice_tick();
    logic [31:0] next_step;
    longint osc, f, high, gain, y;
    logic   up;
    if (gliding) begin
      next_step = step + glide_rate;
      up = !glide_rate[31];
      if (glide_rate == 0 || (up ? next_step >= target : next_step <= target)) begin
        step = target;
        gliding = 1'b0;
      end else begin
        step = next_step;
      end
    end
    phase = phase + step;
    if (!wave_sel) osc = longint'($signed(phase)) >>> 7;
    else osc = phase[31] ? -Q24_ONE : Q24_ONE;
    f = svf_coeff();
    lp_state = int'(longint'(lp_state) + mul_q24(f, longint'(bp_state)));
    high = longint'(int'(osc - lp_state - mul_q24(damping, longint'(bp_state))));
    bp_state = int'(longint'(bp_state) + mul_q24(f, high));
    gain = amp_level;
    if (accented) begin
      gain += mul_q24(amp_level, accent_amt);
      if (gain > GAIN_LIM) gain = GAIN_LIM;
    end
    y = mul_q24(longint'(lp_state), gain) >>> 12;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    cutoff_env = env_clip(mul_q24(cutoff_env, decay));
    amp_level = gate ? Q24_ONE : env_clip(mul_q24(amp_level, decay));
    return 16'(y);
  endfunction

  function automatic void note_on(longint new_step, logic glide, logic acc);
    longint rate, ramp, diff;
    if (glide && step != 0) begin
      rate = (rate_hz != 0) ? rate_hz : 1;
      ramp = (rate * 60) / 1000;
      if (ramp < 1) ramp = 1;
      diff = new_step - longint'(step);
      target = 32'(new_step);
      gliding = 1'b1;
      glide_rate = 32'(diff / ramp);
    end else begin
      step = 32'(new_step);
      target = 32'(new_step);
      gliding = 1'b0;
    end
    cutoff_env = Q24_ONE;
    amp_level = Q24_ONE;
    gate = 1'b1;
    accented = acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      wave_sel = 1'b0; cutoff_pos = 26214; damping = 1928415;
      env_depth = 10066329; decay = 16776612; accent_amt = 8388608; rate_hz = 44100;
      phase = 0; step = 0; target = 0; glide_rate = 0;
      gliding = 1'b0; gate = 1'b0; accented = 1'b0;
      lp_state = 0; bp_state = 0; cutoff_env = 0; amp_level = 0;
      sample_queue.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_WAVEFORM:  wave_sel = cfg_data_i[0];
          REG_CUTOFF:    cutoff_pos = longint'(cfg_data_i[15:0]);
          REG_RESONANCE: damping = longint'(cfg_data_i);
          REG_ENV_MOD:   env_depth = longint'(cfg_data_i);
          REG_DECAY:     decay = longint'(cfg_data_i);
          REG_ACCENT:    accent_amt = longint'(cfg_data_i);
          REG_RATE:      rate_hz = longint'(cfg_data_i[17:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CMD_TICK:     sample_queue.push_back(voice_tick());
          CMD_NOTE_ON:  note_on(longint'(note_step_i), slide_i, accent_i);
          CMD_NOTE_OFF: gate = 1'b0;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (sample_queue.size() == 0) begin
          $error("unexpected sample transfer: sample actual %0d", sample_i);
          fails++;
        end else begin
          want = sample_queue.pop_front();
          if (sample_i !== want) begin
            $error("sample mismatch: expected %0d actual %0d", want, sample_i);
            fails++;
          end
        end
      end
    end
  end

endmodule

/* verif/tb_resonant_bass_synth_voice_core.sv */
`timescale 1ns / 1ps
// Top of the resonant bass voice testbench: clock, reset, command and register
// stimulus, and the verdict. Depends on rbsv_pkg and rbsv_voice_checker.
module tb_resonant_bass_synth_voice_core;
  import rbsv_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         command_i = CMD_TICK;
  logic [30:0]        note_step_i = '0;
  logic               slide_i = 1'b0;
  logic               accent_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] sample_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = REG_WAVEFORM;
  logic [24:0]        cfg_data_i = '0;

  int fail_count, pending, cycles;
  int send_idle_pct, stall_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  resonant_bass_synth_voice_core dut (.*);

  rbsv_voice_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .note_step_i,
    .slide_i, .accent_i, .out_valid_i(out_valid_o), .out_stall_i, .sample_i(sample_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic send(logic [1:0] cmd, logic [30:0] nstep, logic sl, logic acc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    note_step_i <= nstep;
    slide_i <= sl;
    accent_i <= acc;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [24:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [30:0] pick_step();
    case ($urandom_range(3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(2104533975));
      2: return 31'($urandom_range(50000000, 1000));
      default: return 31'($urandom_range(20000000, 2000000));
    endcase
  endfunction

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 72) send(CMD_TICK, 31'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 88) send(CMD_NOTE_ON, pick_step(), 1'($urandom), 1'($urandom));
      else if (r < 96) send(CMD_NOTE_OFF, 31'($urandom), 1'($urandom), 1'($urandom));
      else send(CMD_UNUSED, 31'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic ticks(int n);
    repeat (n) send(CMD_TICK, '0, 1'b0, 1'b0);
  endtask

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(CMD_NOTE_ON, 31'd0, 1'b1, 1'b0);
    ticks(2);
    send(CMD_NOTE_ON, 31'd2104533975, 1'b0, 1'b1);
    ticks(3);
    send(CMD_NOTE_ON, 31'h7FFFFFFF, 1'b1, 1'b1);
    ticks(2);
    send(CMD_NOTE_ON, 31'd5000000, 1'b0, 1'b0);
    send(CMD_NOTE_ON, 31'd5000001, 1'b1, 1'b0);
    ticks(2);
    send(CMD_NOTE_OFF, '0, 1'b0, 1'b0);
    send(CMD_UNUSED, 31'h7FFFFFFF, 1'b1, 1'b1);
    ticks(3);
    settle();

    write_reg(REG_WAVEFORM, 25'd1);
    write_reg(REG_RATE, 25'd8000);
    write_reg(REG_ENV_MOD, 25'd16777216);
    write_reg(REG_ACCENT, 25'd16777216);
    send(CMD_NOTE_ON, 31'd1000000, 1'b0, 1'b1);
    send(CMD_NOTE_ON, 31'd9000000, 1'b1, 1'b1);
    random_items(250);
    settle();

    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      case (phase_no % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      case (phase_no)
        0: begin
          write_reg(REG_WAVEFORM, 25'd0);
          write_reg(REG_CUTOFF, 25'd0);
          write_reg(REG_RESONANCE, 25'd1398101);
          write_reg(REG_DECAY, 25'd16777216);
          write_reg(REG_RATE, 25'd192000);
        end
        1: begin
          write_reg(REG_CUTOFF, 25'd65535);
          write_reg(REG_RESONANCE, 25'd16777216);
          write_reg(REG_ENV_MOD, 25'd0);
          write_reg(REG_DECAY, 25'd0);
          write_reg(REG_ACCENT, 25'd0);
          write_reg(REG_RATE, 25'd0);
        end
        2: begin
          write_reg(REG_WAVEFORM, 25'd1);
          write_reg(REG_CUTOFF, 25'($urandom_range(65535)));
          write_reg(REG_RESONANCE, 25'h1FFFFFF);
          write_reg(REG_ENV_MOD, 25'h1FFFFFF);
          write_reg(REG_DECAY, 25'h1FFFFFF);
          write_reg(REG_ACCENT, 25'h1FFFFFF);
          write_reg(REG_RATE, 25'h1FFFFFF);
        end
        3: begin
          write_reg(REG_RESONANCE, 25'd1928415);
          write_reg(REG_ENV_MOD, 25'd10066329);
          write_reg(REG_DECAY, 25'd16700000);
          write_reg(REG_ACCENT, 25'd8388608);
          write_reg(REG_RATE, 25'd8000);
        end
        4: begin
          write_reg(REG_WAVEFORM, 25'd0);
          write_reg(REG_CUTOFF, 25'd26214);
          write_reg(REG_DECAY, 25'd16776612);
          write_reg(REG_RATE, 25'd44100);
        end
        default: begin
          write_reg(REG_WAVEFORM, 25'($urandom));
          write_reg(REG_CUTOFF, 25'($urandom));
          write_reg(REG_RESONANCE, 25'($urandom_range(16777216, 1398101)));
          write_reg(REG_ENV_MOD, 25'($urandom_range(16777216)));
          write_reg(REG_DECAY, 25'($urandom_range(16777216, 16000000)));
          write_reg(REG_ACCENT, 25'($urandom_range(16777216)));
          write_reg(REG_RATE, 25'($urandom_range(192000, 8000)));
        end
      endcase
      random_items(250);
      settle();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
design/rbsv_pkg.sv
design/resonant_bass_synth_voice_core.sv
verif/rbsv_voice_checker.sv
verif/tb_resonant_bass_synth_voice_core.sv
